FILE: src/hse_pkg.sv
// shared types and constants for the huffman symbol encoder
package hse_pkg;

    localparam int OpW    = 2;
    localparam int SymW   = 8;
    localparam int LenW   = 6;
    localparam int CodeW  = 32;
    localparam int ByteW  = 8;
    localparam int CountW = 48;
    localparam int MaxOut = 4;
    localparam int NbW    = 3;
    localparam int PcntW  = 3;
    localparam int WinW   = CodeW + ByteW;
    localparam int OutW   = MaxOut * ByteW;

    // operation codes of an input item
    typedef enum logic [OpW-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } op_t;

    // results of one item, handed from the packer to the output buffer
    typedef struct packed {
        logic [OutW-1:0]   bytes;
        logic [NbW-1:0]    nbytes;
        logic [CountW-1:0] total;
    } res_t;

endpackage

FILE: src/hse_ram.sv
// generic single write port ram with registered read
module hse_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/hse_table.sv
// code table: length and code bits in ram, per-entry valid bits for the empty reset
module hse_table #(
    parameter int NUM_SYMBOLS  = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [$clog2(NUM_SYMBOLS)-1:0] wr_addr,
    input  logic [hse_pkg::LenW-1:0]       wr_len,
    input  logic [hse_pkg::CodeW-1:0]      wr_code,
    input  logic                           rd_en,
    input  logic [$clog2(NUM_SYMBOLS)-1:0] rd_addr,
    output logic [hse_pkg::LenW-1:0]       rd_len,
    output logic [hse_pkg::CodeW-1:0]      rd_code
);
    import hse_pkg::*;

    localparam int EntryW = LenW + CodeW;
    localparam int LenCap = (MAX_CODE_LEN < CodeW) ? MAX_CODE_LEN : CodeW;
    localparam logic [LenW-1:0] LEN_CAP = LenW'(LenCap);

    logic [NUM_SYMBOLS-1:0] valid_reg;
    logic [NUM_SYMBOLS-1:0] valid_next;
    logic                   rd_valid_reg;
    logic                   rd_valid_next;
    logic [LenW-1:0]        len_sat;
    logic [CodeW:0]         code_mask;
    logic [EntryW-1:0]      wr_entry;
    logic [EntryW-1:0]      rd_entry;

    // saturate the length and drop code bits above it
    always_comb begin
        len_sat   = (wr_len > LEN_CAP) ? LEN_CAP : wr_len;
        code_mask = ((CodeW+1)'(1) << len_sat) - (CodeW+1)'(1);
        wr_entry  = {len_sat, wr_code & code_mask[CodeW-1:0]};
    end

    hse_ram #(
        .WIDTH(EntryW),
        .DEPTH(NUM_SYMBOLS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    // valid bits, read alongside the ram
    always_comb begin
        valid_next = valid_reg;
        if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
        rd_valid_next = rd_en ? valid_reg[rd_addr] : rd_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // an entry never loaded reads as an empty code
    assign rd_len  = rd_valid_reg ? rd_entry[EntryW-1:CodeW] : '0;
    assign rd_code = rd_entry[CodeW-1:0];

endmodule

FILE: src/hse_packer.sv
// bit packer: appends one code to the partial byte and splits off full bytes; a flush emits a nonempty partial byte
module hse_packer (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      proc,
    input  hse_pkg::op_t              op,
    input  logic                      sym_ok,
    input  logic [hse_pkg::LenW-1:0]  len,
    input  logic [hse_pkg::CodeW-1:0] code,
    output hse_pkg::res_t             res
);
    import hse_pkg::*;

    logic [ByteW-1:0]  pbyte_reg;
    logic [ByteW-1:0]  pbyte_next;
    logic [PcntW-1:0]  pcount_reg;
    logic [PcntW-1:0]  pcount_next;
    logic [CountW-1:0] total_reg;
    logic [CountW-1:0] total_next;
    logic [LenW-1:0]   eff_len;
    logic [WinW-1:0]   win;
    logic [WinW-1:0]   acc;
    logic [WinW-1:0]   rest;
    logic [LenW-1:0]   fill;
    logic [NbW-1:0]    nb;

    // align the code under the free bits of the partial byte
    always_comb begin
        eff_len = sym_ok ? len : '0;
        win     = {code, {ByteW{1'b0}}} << (LenW'(CodeW) - eff_len);
        acc     = {pbyte_reg, {CodeW{1'b0}}} | (win >> pcount_reg);
        fill    = LenW'(pcount_reg) + eff_len;
        nb      = fill[LenW-1:PcntW];
        rest    = acc << {nb, {PcntW{1'b0}}};
    end

    // next packer state and results of the item
    always_comb begin
        pbyte_next  = pbyte_reg;
        pcount_next = pcount_reg;
        total_next  = total_reg;
        res.bytes   = acc[WinW-1:ByteW];
        res.nbytes  = '0;
        res.total   = total_reg;
        case (op)
            OP_ENCODE: begin
                pbyte_next  = rest[WinW-1:CodeW];
                pcount_next = fill[PcntW-1:0];
                total_next  = total_reg + CountW'(eff_len);
                res.nbytes  = nb;
                res.total   = total_next;
            end
            OP_FLUSH: begin
                if (pcount_reg != '0) begin
                    res.bytes   = {pbyte_reg, {(OutW-ByteW){1'b0}}};
                    res.nbytes  = NbW'(1);
                    pbyte_next  = '0;
                    pcount_next = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pbyte_reg  <= '0;
            pcount_reg <= '0;
            total_reg  <= '0;
        end else if (proc) begin
            pbyte_reg  <= pbyte_next;
            pcount_reg <= pcount_next;
            total_reg  <= total_next;
        end
    end

endmodule

FILE: src/hse_out_buf.sv
// result register: holds up to four bytes of one item and hands them out one a cycle while the receiver is ready
module hse_out_buf (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  hse_pkg::res_t              res,
    output logic                       free,
    input  logic                       m_ready,
    output logic                       m_valid,
    output logic [hse_pkg::ByteW-1:0]  m_out_byte,
    output logic                       m_last_of_run,
    output logic [hse_pkg::CountW-1:0] m_total_bits
);
    import hse_pkg::*;

    logic [OutW-1:0]   bytes_reg;
    logic [OutW-1:0]   bytes_next;
    logic [NbW-1:0]    cnt_reg;
    logic [NbW-1:0]    cnt_next;
    logic [CountW-1:0] total_reg;
    logic [CountW-1:0] total_next;
    logic              take;

    // handshake and free slot for the next item
    always_comb begin
        m_valid = (cnt_reg != '0);
        take    = m_valid && m_ready;
        free    = (cnt_reg == '0) || (take && cnt_reg == NbW'(1));
    end

    // load a new item or shift out the byte just taken
    always_comb begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        total_next = total_reg;
        if (load) begin
            bytes_next = res.bytes;
            cnt_next   = res.nbytes;
            total_next = res.total;
        end else if (take) begin
            bytes_next = bytes_reg << ByteW;
            cnt_next   = cnt_reg - NbW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
        total_reg <= total_next;
    end

    assign m_out_byte    = bytes_reg[OutW-1:OutW-ByteW];
    assign m_last_of_run = (cnt_reg == NbW'(1));
    assign m_total_bits  = total_reg;

endmodule

FILE: src/huffman_symbol_encoder.sv
// path: an accepted item's table entry is read into the ram output register as the item enters the input stage,
// then the item is packed into the result register once that register is free
// throughput: one item per cycle unless the output stalls; a k-byte item holds the output until all k are taken
// rate is set by the registered table ram read and the one-pass packer into the result register
// an item yielding up to one byte never stalls the input while the output keeps up
// reset (aresetn, synchronous, active low) empties the code table through per-entry valid bits,
// clears the partial byte and the bit count; no clearing pass is needed
module huffman_symbol_encoder #(
    parameter int MAX_CODE_LEN = 32,
    parameter int NUM_SYMBOLS  = 256
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [hse_pkg::OpW-1:0]    s_operation,
    input  logic [hse_pkg::SymW-1:0]   s_symbol,
    input  logic [hse_pkg::LenW-1:0]   s_code_length,
    input  logic [hse_pkg::CodeW-1:0]  s_code_bits,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [hse_pkg::ByteW-1:0]  m_out_byte,
    output logic                       m_last_of_run,
    output logic [hse_pkg::CountW-1:0] m_total_bits
);
    import hse_pkg::*;

    localparam int AddrW = $clog2(NUM_SYMBOLS);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    op_t                 s1_op_reg;
    op_t                 s1_op_next;
    logic                s1_sym_ok_reg;
    logic                s1_sym_ok_next;
    logic                accept;
    logic                proc;
    logic                free;
    logic                sym_ok;
    logic [LenW-1:0]     tbl_len;
    logic [CodeW-1:0]    tbl_code;
    res_t                res;

    // input stage handshake
    always_comb begin
        s_ready = !s1_valid_reg || free;
        accept  = s_valid && s_ready;
        proc    = s1_valid_reg && free;
        sym_ok  = ((SymW+1)'(s_symbol) < (SymW+1)'(NUM_SYMBOLS));
    end

    always_comb begin
        s1_valid_next  = s1_valid_reg;
        s1_op_next     = s1_op_reg;
        s1_sym_ok_next = s1_sym_ok_reg;
        if (accept) begin
            s1_valid_next  = 1'b1;
            s1_op_next     = op_t'(s_operation);
            s1_sym_ok_next = sym_ok;
        end else if (proc) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_op_reg     <= s1_op_next;
        s1_sym_ok_reg <= s1_sym_ok_next;
    end

    // code table: in-range loads write at accept, every accepted item reads its entry
    hse_table #(
        .NUM_SYMBOLS  (NUM_SYMBOLS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (accept && sym_ok && (op_t'(s_operation) == OP_LOAD)),
        .wr_addr (s_symbol[AddrW-1:0]),
        .wr_len  (s_code_length),
        .wr_code (s_code_bits),
        .rd_en   (accept),
        .rd_addr (s_symbol[AddrW-1:0]),
        .rd_len  (tbl_len),
        .rd_code (tbl_code)
    );

    hse_packer u_packer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .proc    (proc),
        .op      (s1_op_reg),
        .sym_ok  (s1_sym_ok_reg),
        .len     (tbl_len),
        .code    (tbl_code),
        .res     (res)
    );

    hse_out_buf u_out_buf (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (proc),
        .res           (res),
        .free          (free),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run),
        .m_total_bits  (m_total_bits)
    );

`ifndef SYNTHESIS
    // an empty input stage always takes an item
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_ready)
        else $error("input stage empty but not ready");

    // after the last byte of an item, new bytes come only from a newly packed item
    a_no_invented_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_of_run) |=> (!m_valid || $past(proc)))
        else $error("result appeared without a packed item");

    // bytes of one item keep coming with the same bit count
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> (m_valid && $stable(m_total_bits)))
        else $error("run of bytes broken or count changed mid-run");
`endif

endmodule

FILE: bench/huffman_symbol_encoder_checker.sv
`timescale 1ns / 100ps
// stream checker for the huffman symbol encoder: predicts packed bytes and compares them
module huffman_symbol_encoder_checker #(
    parameter int MAX_CODE_LEN = 32,
    parameter int NUM_SYMBOLS  = 256
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [hse_pkg::OpW-1:0]    s_operation,
    input  logic [hse_pkg::SymW-1:0]   s_symbol,
    input  logic [hse_pkg::LenW-1:0]   s_code_length,
    input  logic [hse_pkg::CodeW-1:0]  s_code_bits,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [hse_pkg::ByteW-1:0]  m_out_byte,
    input  logic                       m_last_of_run,
    input  logic [hse_pkg::CountW-1:0] m_total_bits,
    output int unsigned                err_count,
    output int unsigned                pending
);
    import hse_pkg::*;

    typedef struct packed {
        logic [ByteW-1:0]  data;
        logic              last;
        logic [CountW-1:0] total;
    } packed_byte_t;

    // bytes predicted but not yet seen on the output
    packed_byte_t     byte_queue[$];

    // shadow copy of the code table and the packer
    logic [LenW-1:0]   len_table[256];
    logic [CodeW-1:0]  bits_table[256];
    logic [ByteW-1:0]  acc_byte;
    int                acc_count;
    logic [CountW-1:0] bit_total;

    initial begin
        err_count = 0;
        pending   = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        err_count++;
    endtask

    // apply one accepted item to the shadow packer, queueing the bytes it yields
    task automatic pack_item(input logic [OpW-1:0] op, input logic [SymW-1:0] sym,
                             input logic [LenW-1:0] len, input logic [CodeW-1:0] bits);
        int           eff_len;
        int           nbytes;
        int           emitted;
        packed_byte_t pb;
        emitted = 0;
        case (op_t'(op))
            OP_LOAD: begin
                if (sym < NUM_SYMBOLS) begin
                    eff_len = len;
                    if (eff_len > MAX_CODE_LEN) eff_len = MAX_CODE_LEN;
                    if (eff_len > 32) eff_len = 32;
                    len_table[sym]  = LenW'(eff_len);
                    bits_table[sym] = bits;
                end
            end
            OP_ENCODE: begin
                if (sym < NUM_SYMBOLS) begin
                    eff_len   = len_table[sym];
                    nbytes    = (acc_count + eff_len) / 8;
                    bit_total = bit_total + CountW'(eff_len);
                    // shift code bits in, most significant first
                    for (int i = eff_len; i > 0; i--) begin
                        acc_byte[7 - acc_count] = bits_table[sym][i - 1];
                        acc_count++;
                        if (acc_count == 8) begin
                            pb.data  = acc_byte;
                            pb.last  = (emitted == nbytes - 1);
                            pb.total = bit_total;
                            byte_queue.push_back(pb);
                            emitted++;
                            acc_byte  = '0;
                            acc_count = 0;
                        end
                    end
                end
            end
            OP_FLUSH: begin
                if (acc_count != 0) begin
                    pb.data  = acc_byte;
                    pb.last  = 1'b1;
                    pb.total = bit_total;
                    byte_queue.push_back(pb);
                    acc_byte  = '0;
                    acc_count = 0;
                end
            end
            default: ;
        endcase
    endtask

    // watch both channels at every rising edge
    always @(posedge aclk) begin
        packed_byte_t want;
        if (!aresetn) begin
            byte_queue.delete();
            for (int i = 0; i < 256; i++) begin
                len_table[i]  = '0;
                bits_table[i] = '0;
            end
            acc_byte  = '0;
            acc_count = 0;
            bit_total = '0;
        end else begin
            if (m_valid && m_ready) begin
                if (byte_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %h", m_out_byte));
                end else begin
                    want = byte_queue.pop_front();
                    if (m_out_byte !== want.data)
                        report_mismatch($sformatf("out_byte %h, want %h",
                                                  m_out_byte, want.data));
                    if (m_last_of_run !== want.last)
                        report_mismatch($sformatf("last_of_run %b, want %b",
                                                  m_last_of_run, want.last));
                    if (m_total_bits !== want.total)
                        report_mismatch($sformatf("total_bits %0d, want %0d",
                                                  m_total_bits, want.total));
                end
            end
            if (s_valid && s_ready)
                pack_item(s_operation, s_symbol, s_code_length, s_code_bits);
        end
        pending <= byte_queue.size();
    end

endmodule

FILE: bench/huffman_symbol_encoder_test.sv
`timescale 1ns / 100ps
// top of the huffman symbol encoder bench: clock, reset, stimulus and verdict
module huffman_symbol_encoder_test;
    import hse_pkg::*;

    localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

    logic              aclk;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [OpW-1:0]    s_operation   = '0;
    logic [SymW-1:0]   s_symbol      = '0;
    logic [LenW-1:0]   s_code_length = '0;
    logic [CodeW-1:0]  s_code_bits   = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [ByteW-1:0]  m_out_byte;
    logic              m_last_of_run;
    logic [CountW-1:0] m_total_bits;

    int unsigned err_count;
    int unsigned pending;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    // symbols that have had a table entry loaded
    logic [SymW-1:0] loaded_syms[$];

    huffman_symbol_encoder uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_symbol      (s_symbol),
        .s_code_length (s_code_length),
        .s_code_bits   (s_code_bits),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run),
        .m_total_bits  (m_total_bits)
    );

    huffman_symbol_encoder_checker stream_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_symbol      (s_symbol),
        .s_code_length (s_code_length),
        .s_code_bits   (s_code_bits),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run),
        .m_total_bits  (m_total_bits),
        .err_count     (err_count),
        .pending       (pending)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver stalls at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // run limit
    initial begin
        #2000000;
        $display("[huffman_symbol_encoder] ERROR");
        $finish;
    end

    // offer one item after a random gap and hold it until accepted
    task automatic send_item(input logic [OpW-1:0] op, input logic [SymW-1:0] sym,
                             input logic [LenW-1:0] len, input logic [CodeW-1:0] bits);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_symbol      <= sym;
        s_code_length <= len;
        s_code_bits   <= bits;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_LOAD) loaded_syms.push_back(sym);
    endtask

    // hold the sender off until every predicted byte has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    initial begin
        int          pick;
        int          send_pcts[3];
        int          recv_pcts[3];
        logic [SymW-1:0]  sym;
        logic [LenW-1:0]  len;
        send_pcts = '{15, 58, 0};
        recv_pcts = '{58, 15, 0};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty codes, empty flush, unused operation
        send_item(OP_ENCODE, 8'd5, 6'd0, 32'h0);
        send_item(OP_FLUSH, 8'd0, 6'd0, 32'h0);
        send_item(OP_UNUSED, 8'hff, 6'h3f, 32'hffff_ffff);
        send_item(OP_LOAD, 8'd0, 6'd0, 32'hffff_ffff);
        send_item(OP_ENCODE, 8'd0, 6'd0, 32'h0);
        // full-width codes, saturated lengths
        send_item(OP_LOAD, 8'd255, 6'd32, 32'hffff_ffff);
        send_item(OP_ENCODE, 8'd255, 6'd0, 32'h0);
        send_item(OP_LOAD, 8'd1, 6'd63, 32'h8000_0001);
        send_item(OP_ENCODE, 8'd1, 6'd0, 32'h0);
        send_item(OP_LOAD, 8'd2, 6'd33, 32'h0);
        send_item(OP_ENCODE, 8'd2, 6'd0, 32'h0);
        // short codes with junk above the length, then partial byte flush
        send_item(OP_LOAD, 8'd3, 6'd3, 32'hffff_fffa);
        send_item(OP_ENCODE, 8'd3, 6'd0, 32'h0);
        send_item(OP_LOAD, 8'd4, 6'd1, 32'h1);
        send_item(OP_ENCODE, 8'd4, 6'd0, 32'h0);
        send_item(OP_FLUSH, 8'd0, 6'd0, 32'h0);
        // long codes on top of a partial byte
        send_item(OP_ENCODE, 8'd3, 6'd0, 32'h0);
        send_item(OP_ENCODE, 8'd255, 6'd0, 32'h0);
        send_item(OP_ENCODE, 8'd1, 6'd0, 32'h0);
        send_item(OP_FLUSH, 8'd0, 6'd0, 32'h0);
        send_item(OP_LOAD, 8'd128, 6'd7, 32'h55);
        send_item(OP_ENCODE, 8'd128, 6'd0, 32'h0);
        send_item(OP_ENCODE, 8'd128, 6'd0, 32'h0);
        send_item(OP_FLUSH, 8'd0, 6'd0, 32'h0);
        drain_results();

        // random phases with different idling on each side
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = send_pcts[phase];
            recv_idle_pct = recv_pcts[phase];
            repeat (123) begin
                pick = $urandom_range(0, 99);
                if (pick < 14) begin
                    // table load with mostly legal lengths
                    pick = $urandom_range(0, 99);
                    if (pick < 10)      len = 6'd0;
                    else if (pick < 20) len = LenW'($urandom_range(33, 63));
                    else if (pick < 70) len = LenW'($urandom_range(1, 12));
                    else                len = LenW'($urandom_range(13, 32));
                    send_item(OP_LOAD, SymW'($urandom_range(0, 255)), len, $urandom());
                end else if (pick < 84) begin
                    // encode, mostly of symbols that have a code
                    if (loaded_syms.size() > 0 && $urandom_range(0, 99) < 85)
                        sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
                    else
                        sym = SymW'($urandom_range(0, 255));
                    send_item(OP_ENCODE, sym, LenW'($urandom_range(0, 63)), $urandom());
                end else if (pick < 95) begin
                    send_item(OP_FLUSH, SymW'($urandom_range(0, 255)),
                              LenW'($urandom_range(0, 63)), $urandom());
                end else begin
                    send_item(OP_UNUSED, SymW'($urandom_range(0, 255)),
                              LenW'($urandom_range(0, 63)), $urandom());
                end
            end
            drain_results();
        end

        // let the pipeline settle
        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("[huffman_symbol_encoder] OK");
        end else begin
            $display("[huffman_symbol_encoder] ERROR");
        end
        $finish;
    end

endmodule
